// ===== hw/rtl/telrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telrf_pkg: shared types and constants of the telnet receive filter
// Byte codes of the protocol, the queued command format and the functions
// that expand one command into its output beats.
// ----------------------------------------------------------------------------
package telrf_pkg;

  // telnet command bytes
  localparam logic [7:0] ByteIac  = 8'd255;
  localparam logic [7:0] ByteDont = 8'd254;
  localparam logic [7:0] ByteDo   = 8'd253;
  localparam logic [7:0] ByteWont = 8'd252;
  localparam logic [7:0] ByteWill = 8'd251;
  localparam logic [7:0] ByteSb   = 8'd250;
  localparam logic [7:0] ByteSe   = 8'd240;
  localparam logic [7:0] ByteIp   = 8'd244;
  localparam logic [7:0] OptEcho  = 8'd1;

  // ascii codes used by the echo path
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChCtrlC = 8'h03;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChEsc   = 8'h1b;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCaret = 8'h5e;
  localparam logic [7:0] ChUpC   = 8'h43;
  localparam logic [7:0] ChDel   = 8'h7f;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChTilde = 8'h7e;

  // beat index within one command, up to five beats
  localparam int unsigned IdxW = 3;

  // what one accepted byte turns into
  typedef enum logic [2:0] {
    CmdNeg,    // iac, reply verb, option to the peer
    CmdPlain,  // shell byte only
    CmdSelf,   // echo byte, shell byte
    CmdFf,     // echo ff ff, shell byte
    CmdCrlf,   // echo cr lf, shell byte
    CmdErase,  // echo bs space bs, shell byte
    CmdCtrlc   // echo ^ C cr lf, shell byte
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic [7:0] resp;
  } cmd_t;

  // number of beats of a command
  function automatic logic [IdxW-1:0] seq_len(input cmd_kind_e kind);
    logic [IdxW-1:0] len;
    case (kind)
      CmdNeg:   len = 3'd3;
      CmdPlain: len = 3'd1;
      CmdSelf:  len = 3'd2;
      CmdFf:    len = 3'd3;
      CmdCrlf:  len = 3'd3;
      CmdErase: len = 3'd4;
      CmdCtrlc: len = 3'd5;
      default:  len = 3'd1;
    endcase
    return len;
  endfunction

  // byte of beat idx; the final beat of a data command is the shell byte
  function automatic logic [7:0] seq_byte(input cmd_t cmd, input logic [IdxW-1:0] idx);
    logic [7:0] b;
    logic       fin;
    fin = (idx == IdxW'(seq_len(cmd.kind) - 3'd1));
    b   = cmd.data;
    case (cmd.kind)
      CmdNeg: begin
        if (idx == 3'd0) b = ByteIac;
        else if (idx == 3'd1) b = cmd.resp;
        else b = cmd.data;
      end
      CmdPlain, CmdSelf: b = cmd.data;
      CmdFf:   b = ByteIac;
      CmdCrlf: b = (idx == 3'd0) ? ChCr : ChLf;
      CmdErase: b = (idx == 3'd1) ? ChSpace : ChBs;
      CmdCtrlc: begin
        case (idx)
          3'd0:    b = ChCaret;
          3'd1:    b = ChUpC;
          3'd2:    b = ChCr;
          default: b = ChLf;
        endcase
      end
      default: b = cmd.data;
    endcase
    if (fin && cmd.kind != CmdNeg) b = cmd.data;
    return b;
  endfunction

  // every beat goes to the peer except the shell byte
  function automatic logic seq_peer(input cmd_t cmd, input logic [IdxW-1:0] idx);
    return (cmd.kind == CmdNeg) || (idx != IdxW'(seq_len(cmd.kind) - 3'd1));
  endfunction

endpackage

// ===== hw/rtl/telrf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telrf_front: telnet parser and classifier
// Follows iac, option and subnegotiation framing, tracks the echo escape
// state and pushes one command per byte that causes output.
// ----------------------------------------------------------------------------
module telrf_front
  import telrf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_data_i,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  output logic       q_push_o,
  output cmd_t       q_cmd_o
);

  typedef enum logic [2:0] {
    PsData,
    PsIac,
    PsOption,
    PsSub,
    PsSubIac
  } pst_e;

  pst_e       state_q, state_d;
  logic [7:0] verb_q, verb_d;
  logic       after_cr_q, after_cr_d;
  logic       esc_q, esc_d;
  logic       echo_en_q;

  logic       dlv;
  logic [7:0] dval;

  // parser next state
  always_comb begin
    state_d    = state_q;
    verb_d     = verb_q;
    after_cr_d = after_cr_q;
    esc_d      = esc_q;
    dlv        = 1'b0;
    dval       = in_byte_i;
    q_push_o   = 1'b0;
    q_cmd_o    = '{kind: CmdPlain, data: in_byte_i, resp: ByteWont};
    if (accept_i) begin
      case (state_q)
        PsSub: begin
          if (in_byte_i == ByteIac) state_d = PsSubIac;
        end
        PsSubIac: begin
          state_d = (in_byte_i == ByteSe) ? PsData : PsSub;
        end
        PsOption: begin
          state_d = PsData;
          if (verb_q == ByteDo) begin
            q_push_o     = 1'b1;
            q_cmd_o.kind = CmdNeg;
            q_cmd_o.resp = (in_byte_i == OptEcho) ? ByteWill : ByteWont;
          end else if (verb_q == ByteWill) begin
            q_push_o     = 1'b1;
            q_cmd_o.kind = CmdNeg;
            q_cmd_o.resp = ByteDont;
          end
        end
        PsIac: begin
          if (in_byte_i == ByteIac) begin
            state_d = PsData;
            dlv     = 1'b1;
          end else if (in_byte_i inside {ByteDo, ByteDont, ByteWill, ByteWont}) begin
            verb_d  = in_byte_i;
            state_d = PsOption;
          end else if (in_byte_i == ByteSb) begin
            state_d = PsSub;
          end else begin
            state_d = PsData;
            if (in_byte_i == ByteIp) begin
              dlv  = 1'b1;
              dval = ChCtrlC;
            end
          end
        end
        default: begin
          state_d = PsData;
          if (in_byte_i == ByteIac) begin
            state_d = PsIac;
          end else if (after_cr_q && (in_byte_i == ChNul || in_byte_i == ChLf)) begin
            after_cr_d = 1'b0;
          end else begin
            after_cr_d = (in_byte_i == ChCr);
            dlv        = 1'b1;
          end
        end
      endcase
    end

    // echo classification of a delivered byte
    if (dlv) begin
      q_push_o     = 1'b1;
      q_cmd_o.data = dval;
      q_cmd_o.kind = CmdPlain;
      if (echo_en_q) begin
        if (esc_q) begin
          if (dval inside {[ChAt:ChTilde]}) esc_d = 1'b0;
        end else if (dval == ChEsc) begin
          esc_d = 1'b1;
        end else if (dval == ChCr || dval == ChLf) begin
          q_cmd_o.kind = CmdCrlf;
        end else if (dval == ChBs || dval == ChDel) begin
          q_cmd_o.kind = CmdErase;
        end else if (dval == ChCtrlC) begin
          q_cmd_o.kind = CmdCtrlc;
        end else if (dval == ByteIac) begin
          q_cmd_o.kind = CmdFf;
        end else if (dval >= ChSpace || dval == ChTab) begin
          q_cmd_o.kind = CmdSelf;
        end
      end
    end
  end

  // parser state and echo enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= PsData;
      verb_q     <= 8'd0;
      after_cr_q <= 1'b0;
      esc_q      <= 1'b0;
      echo_en_q  <= 1'b1;
    end else begin
      state_q    <= state_d;
      verb_q     <= verb_d;
      after_cr_q <= after_cr_d;
      esc_q      <= esc_d;
      if (cfg_valid_i) echo_en_q <= cfg_data_i;
    end
  end

endmodule

// ===== hw/rtl/telrf_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telrf_fifo: command queue between parser and beat sequencer
// Register-based queue with a fall-through head.
// ----------------------------------------------------------------------------
module telrf_fifo
  import telrf_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t rdata_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count exceeds depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command pushed into full queue");

endmodule

// ===== hw/rtl/telrf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telrf_back: beat sequencer
// Expands the queue head into its output beats, one a cycle while results
// are popped, through an output register holding the oldest waiting result.
// ----------------------------------------------------------------------------
module telrf_back
  import telrf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       head_i,
  input  logic       head_vld_i,
  output logic       head_pop_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       to_peer_o,
  output logic       last_o
);

  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] len;
  logic            out_vld_q;
  logic            adv, beat_last;

  assign len        = seq_len(head_i.kind);
  assign beat_last  = (idx_q == IdxW'(len - 3'd1));
  assign adv        = head_vld_i && (!out_vld_q || pop);
  assign head_pop_o = adv && beat_last;
  assign empty      = !out_vld_q;

  // beat index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) idx_q <= beat_last ? '0 : idx_q + 1'b1;
      if (adv) out_vld_q <= 1'b1;
      else if (pop) out_vld_q <= 1'b0;
    end
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_o <= seq_byte(head_i, idx_q);
      to_peer_o  <= seq_peer(head_i, idx_q);
      last_o     <= beat_last;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_vld_i |-> (idx_q < len))
    else $error("beat index past command length");

  a_shell_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !to_peer_o) |-> last_o)
    else $error("shell byte not marked last");

  a_idx_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !beat_last) |=> (idx_q != '0))
    else $error("beat index did not advance");

endmodule

// ===== hw/rtl/telnet_receive_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_receive_filter_top: telnet receive filter with server-side echo
// Parses received telnet bytes, answers option negotiation and emits echo
// bytes for the peer and data bytes for the shell.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: a byte is taken on a clock edge with
//   push high and full low. Result side is a queue read port: the oldest
//   result sits on out_byte_o / to_peer_o / last_o while empty is low and
//   is taken on an edge with pop high. last_o marks the final result of
//   one input byte; bytes that cause nothing produce no beat.
//   The first beat of a byte passes through the command queue and then
//   the output register before it shows on the result ports. Each
//   byte yields 0 to 5 beats and the output register sends one beat a
//   cycle while pop is high, so an ordinary echoed byte yields 2 beats,
//   a negotiation reply 3 and an echoed control-C 5. Input is taken
//   every cycle while the command queue (QueueDepth entries) has room,
//   independent of the result side.
//   The cfg channel writes echo_enabled (always ready); write it only while
//   the block is idle. Reset puts the parser in the data state, echo on.
//   When pop stays low the output register holds, the queue fills and full
//   rises; no beat is lost.
// ----------------------------------------------------------------------------
module telnet_receive_filter_top
  import telrf_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       to_peer_o,
  output logic       last_o
);

  logic accept;
  logic q_push, q_pop, q_empty;
  cmd_t q_wcmd, q_head;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // parser front
  telrf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .q_push_o    (q_push),
    .q_cmd_o     (q_wcmd)
  );

  // command queue
  telrf_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wcmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .rdata_o (q_head),
    .empty_o (q_empty)
  );

  // beat sequencer
  telrf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (q_head),
    .head_vld_i (!q_empty),
    .head_pop_o (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte_o),
    .to_peer_o  (to_peer_o),
    .last_o     (last_o)
  );

endmodule

// ===== tb/telnet_receive_filter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_receive_filter_checker: beat scoreboard for the telnet receive filter
// Follows the parser, option negotiation and echo translation for every byte
// taken on the input side, queues the beats that byte must produce and
// compares each beat taken on the result side against the oldest one queued.
// ----------------------------------------------------------------------------
module telnet_receive_filter_checker
  import telrf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic       cfg_data_i,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] in_byte_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic [7:0] out_byte_i,
  input  logic       to_peer_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         bytes_o,
  output int         beats_o,
  output int         peer_beats_o
);

  typedef enum logic [2:0] {
    PsData,
    PsIac,
    PsOption,
    PsSub,
    PsSubIac
  } parse_e;

  typedef struct packed {
    logic [7:0] data;
    logic       peer;
    logic       is_last;
  } beat_t;

  // model copy of the block state
  parse_e     pstate;
  logic [7:0] verb;
  logic       after_cr;
  logic       in_escape;
  logic       echo_on;

  beat_t beats_q[$];
  int    mismatches;
  int    byte_count;
  int    beat_count;
  int    peer_count;

  assign fail_count_o = mismatches;
  assign bytes_o      = byte_count;
  assign beats_o      = beat_count;
  assign peer_beats_o = peer_count;

  function automatic void add_beat(input logic [7:0] b, input logic peer);
    beat_t bt;
    bt.data    = b;
    bt.peer    = peer;
    bt.is_last = 1'b0;
    beats_q.push_back(bt);
  endfunction

  // echo translation toward the peer
  function automatic void echo_beats(input logic [7:0] b);
    if (!echo_on) return;
    if (in_escape) begin
      if (b >= ChAt && b <= ChTilde) in_escape = 1'b0;
      return;
    end
    if (b == ChEsc) begin
      in_escape = 1'b1;
    end else if (b == ChCr || b == ChLf) begin
      add_beat(ChCr, 1'b1);
      add_beat(ChLf, 1'b1);
    end else if (b == ChBs || b == ChDel) begin
      add_beat(ChBs, 1'b1);
      add_beat(ChSpace, 1'b1);
      add_beat(ChBs, 1'b1);
    end else if (b == ChCtrlC) begin
      add_beat(ChCaret, 1'b1);
      add_beat(ChUpC, 1'b1);
      add_beat(ChCr, 1'b1);
      add_beat(ChLf, 1'b1);
    end else if (b >= ChSpace || b == ChTab) begin
      add_beat(b, 1'b1);
      if (b == ByteIac) add_beat(b, 1'b1);
    end
  endfunction

  function automatic void deliver(input logic [7:0] b);
    echo_beats(b);
    add_beat(b, 1'b0);
  endfunction

  // one received byte through the parser
  function automatic void filter_byte(input logic [7:0] b);
    int base;
    base = beats_q.size();
    case (pstate)
      PsSub: begin
        if (b == ByteIac) pstate = PsSubIac;
      end
      PsSubIac: begin
        pstate = (b == ByteSe) ? PsData : PsSub;
      end
      PsOption: begin
        if (verb == ByteDo) begin
          add_beat(ByteIac, 1'b1);
          add_beat((b == OptEcho) ? ByteWill : ByteWont, 1'b1);
          add_beat(b, 1'b1);
        end else if (verb == ByteWill) begin
          add_beat(ByteIac, 1'b1);
          add_beat(ByteDont, 1'b1);
          add_beat(b, 1'b1);
        end
        pstate = PsData;
      end
      PsIac: begin
        if (b == ByteIac) begin
          pstate = PsData;
          deliver(b);
        end else if (b == ByteDo || b == ByteDont || b == ByteWill || b == ByteWont) begin
          verb   = b;
          pstate = PsOption;
        end else if (b == ByteSb) begin
          pstate = PsSub;
        end else begin
          pstate = PsData;
          if (b == ByteIp) deliver(ChCtrlC);
        end
      end
      default: begin
        pstate = PsData;
        if (b == ByteIac) begin
          pstate = PsIac;
        end else if (after_cr && (b == ChNul || b == ChLf)) begin
          after_cr = 1'b0;
        end else begin
          after_cr = (b == ChCr);
          deliver(b);
        end
      end
    endcase
    // mark the closing beat of this byte
    if (beats_q.size() > base) beats_q[beats_q.size()-1].is_last = 1'b1;
  endfunction

  // watch all three channels on every edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    beat_t want;
    if (!rst_ni) begin
      pstate     = PsData;
      verb       = 8'h00;
      after_cr   = 1'b0;
      in_escape  = 1'b0;
      echo_on    = 1'b1;
      mismatches = 0;
      byte_count = 0;
      beat_count = 0;
      peer_count = 0;
      beats_q.delete();
      pending_o <= 0;
    end else begin
      // result side first: a beat taken now is always older than a new byte
      if (pop_i && !empty_i) begin
        beat_count++;
        if (to_peer_i) peer_count++;
        if (beats_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected beat byte %02h peer %0b last %0b",
                     $realtime, out_byte_i, to_peer_i, last_i);
        end else begin
          want = beats_q.pop_front();
          if (out_byte_i !== want.data || to_peer_i !== want.peer ||
              last_i !== want.is_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: beat differs, expected byte %02h peer %0b last %0b, got byte %02h peer %0b last %0b",
                       $realtime, want.data, want.peer, want.is_last,
                       out_byte_i, to_peer_i, last_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) echo_on = cfg_data_i;
      if (push_i && !full_i) begin
        byte_count++;
        filter_byte(in_byte_i);
      end
      pending_o <= beats_q.size();
    end
  end

endmodule

// ===== tb/telnet_receive_filter_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_receive_filter_top_test: stimulus and verdict for the receive filter
// Feeds a short directed byte stream, then random telnet traffic (data runs,
// line ends, escape sequences, negotiation, subnegotiation and noise) under
// several echo settings, with random gaps on both queue sides.
// ----------------------------------------------------------------------------
module telnet_receive_filter_top_test;
  import telrf_pkg::*;

  localparam logic [7:0] ByteNop    = 8'd241;
  localparam int         PhaseItems = 66;
  localparam int         SettleCyc  = 16;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i  = 1'b0;
  logic       push        = 1'b0;
  logic       full;
  logic [7:0] in_byte_i   = 8'h00;
  logic       empty;
  logic       pop         = 1'b0;
  logic [7:0] out_byte_o;
  logic       to_peer_o;
  logic       last_o;

  int fail_count;
  int pending;
  int bytes_seen;
  int beats_seen;
  int peer_beats;
  int sent_n;
  int settings_n;
  logic src_steady = 1'b0;
  logic sink_steady = 1'b0;

  telnet_receive_filter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .in_byte_i   (in_byte_i),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .to_peer_o   (to_peer_o),
    .last_o      (last_o)
  );

  telnet_receive_filter_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push),
    .full_i       (full),
    .in_byte_i    (in_byte_i),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_byte_i   (out_byte_o),
    .to_peer_i    (to_peer_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .bytes_o      (bytes_seen),
    .beats_o      (beats_seen),
    .peer_beats_o (peer_beats)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side: random pop stalls, with stretches of steady popping
  initial begin : pop_drive
    int hold;
    int span;
    hold = 0;
    span = 0;
    forever begin
      @(posedge clk_i);
      if (span == 0) begin
        span        = $urandom_range(20, 80);
        sink_steady = ($urandom_range(0, 3) == 0);
      end
      span--;
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!sink_steady) hold = pick_gap();
      end
    end
  end

  // one input beat, entered and left on a rising edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (sent_n % 24 == 0) src_steady = ($urandom_range(0, 3) == 0);
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_byte_i <= b;
    do @(posedge clk_i); while (full);
    sent_n++;
  endtask

  // let every queued beat drain, plus a margin for bytes with no beats
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_echo(input logic on);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= on;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    settings_n++;
  endtask

  // one random chunk of telnet traffic
  task automatic send_segment();
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom_range(32, 126)));
    end else if (roll < 35) begin
      send_byte(8'($urandom_range(0, 254)));
    end else if (roll < 43) begin
      send_byte(ChCr);
      case ($urandom_range(0, 2))
        0:       send_byte(ChNul);
        1:       send_byte(ChLf);
        default: send_byte(8'($urandom_range(0, 254)));
      endcase
    end else if (roll < 50) begin
      // escape sequence: parameters then a final byte
      send_byte(ChEsc);
      n = $urandom_range(0, 3);
      repeat (n) send_byte(8'($urandom_range(32, 63)));
      send_byte(8'($urandom_range(ChAt, ChTilde)));
    end else if (roll < 56) begin
      case ($urandom_range(0, 3))
        0:       send_byte(ChBs);
        1:       send_byte(ChDel);
        2:       send_byte(ChCtrlC);
        default: send_byte(ChTab);
      endcase
    end else if (roll < 61) begin
      send_byte(ByteIac);
      send_byte(ByteIac);
    end else if (roll < 65) begin
      send_byte(ByteIac);
      send_byte(ByteIp);
    end else if (roll < 80) begin
      send_byte(ByteIac);
      send_byte(ByteWill + 8'($urandom_range(0, 3)));
      send_byte($urandom_range(0, 1) ? OptEcho : 8'($urandom_range(0, 255)));
    end else if (roll < 88) begin
      // subnegotiation with stray escaped bytes inside
      send_byte(ByteIac);
      send_byte(ByteSb);
      n = $urandom_range(0, 4);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) begin
          send_byte(ByteIac);
          send_byte(8'($urandom_range(0, 239)));
        end else begin
          send_byte(8'($urandom_range(0, 255)));
        end
      end
      send_byte(ByteIac);
      send_byte(ByteSe);
    end else if (roll < 92) begin
      send_byte(ByteIac);
      send_byte(8'($urandom_range(ByteSe, 249)));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int phase_end;
    sent_n     = 0;
    settings_n = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: line ends, erase, control-c, escape, iac cases, negotiation
    send_byte(8'h61);
    send_byte(ChCr);
    send_byte(ChLf);
    send_byte(ChCr);
    send_byte(ChNul);
    send_byte(ChBs);
    send_byte(ChDel);
    send_byte(ChCtrlC);
    send_byte(ChEsc);
    send_byte(8'h31);
    send_byte(8'h41);
    send_byte(ByteIac);
    send_byte(ByteIac);
    send_byte(ByteIac);
    send_byte(ByteIp);
    send_byte(ByteIac);
    send_byte(ByteDo);
    send_byte(OptEcho);
    send_byte(ByteIac);
    send_byte(ByteWill);
    send_byte(8'hff);
    send_byte(ByteIac);
    send_byte(ByteSb);
    send_byte(ByteIac);
    send_byte(ByteSe);
    send_byte(ByteIac);
    send_byte(ByteNop);

    // random traffic, alternating echo off and on
    for (int ph = 0; ph < 4; ph++) begin
      write_echo(ph % 2 == 1);
      phase_end = sent_n + PhaseItems;
      while (sent_n < phase_end) send_segment();
    end

    wait_drained();
    $display("run covered %0d input bytes and %0d output beats (%0d to the peer)",
             bytes_seen, beats_seen, peer_beats);
    $display("traffic ran under %0d echo settings after reset, %0d beat errors",
             settings_n + 1, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("timeout with %0d beats outstanding", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
